// ===== sv/ssai_pkg.sv =====
// ----------------------------------------------------------------------------
// ssai_pkg
// shared types and constants for the sorted segment address index
// ----------------------------------------------------------------------------
package ssai_pkg;

    localparam int CAPACITY         = 64;
    localparam int SEGMENT_LOG_SIZE = 22;
    localparam int ADDR_W           = 48;
    localparam int HANDLE_W         = 16;
    localparam int STATUS_W         = 3;
    localparam int ECOUNT_W         = 7;
    localparam int CNT_W            = $clog2(CAPACITY + 1);

    localparam logic [ADDR_W-1:0] ALIGN_MASK =
        {{(ADDR_W - SEGMENT_LOG_SIZE){1'b1}}, {SEGMENT_LOG_SIZE{1'b0}}};

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [CNT_W-1:0]    count_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_HIT      = 3'd4,
        ST_MISS     = 3'd5
    } status_t;

    typedef enum logic {
        MODE_UPDATE = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic insert;
        logic replace;
    } cell_ctl_t;

    // data handed from one cell to its right neighbor
    typedef struct packed {
        addr_t   key;
        handle_t handle;
        logic    valid;
        logic    lt;
    } cell_link_t;

endpackage

// ===== sv/ssai_cell.sv =====
// ----------------------------------------------------------------------------
// ssai_cell
// one table slot: holds a key and handle, compares against the broadcast
// key and shifts right from its left neighbor on insert
// ----------------------------------------------------------------------------
module ssai_cell
    import ssai_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  addr_t      cmp_key,
    input  addr_t      op_key,
    input  handle_t    op_handle,
    input  cell_link_t left,
    output cell_link_t right,
    output logic       eq,
    output handle_t    hit_handle
);

    addr_t   key_reg,    key_next;
    handle_t handle_reg, handle_next;
    logic    valid_reg,  valid_next;
    logic    eq_reg,     eq_next;
    logic    lt_reg,     lt_next;

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        valid_next  = valid_reg;
        eq_next     = eq_reg;
        lt_next     = lt_reg;
        if (ctl.cmp_en)
        begin
            eq_next = valid_reg && (key_reg == cmp_key);
            lt_next = valid_reg && (key_reg < cmp_key);
        end
        if (ctl.replace && eq_reg)
        begin
            handle_next = op_handle;
        end
        if (ctl.insert && !lt_reg)
        begin
            if (left.lt)
            begin
                // insertion point
                key_next    = op_key;
                handle_next = op_handle;
                valid_next  = 1'b1;
            end
            else
            begin
                key_next    = left.key;
                handle_next = left.handle;
                valid_next  = left.valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            eq_reg    <= 1'b0;
            lt_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            eq_reg    <= eq_next;
            lt_reg    <= lt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign right.key    = key_reg;
    assign right.handle = handle_reg;
    assign right.valid  = valid_reg;
    assign right.lt     = lt_reg;
    assign eq           = eq_reg;
    assign hit_handle   = eq_reg ? handle_reg : '0;

endmodule

// ===== sv/sorted_segment_address_index_top.sv =====
// ----------------------------------------------------------------------------
// sorted_segment_address_index_top
// sorted table of segment base addresses kept in a chain of cells, with
// update/insert and aligned exact-match lookup
// ----------------------------------------------------------------------------
//  channel   handshake        word
//  input     start / busy     mode, address, handle_in
//  result    done (strobe)    status, handle_out, entry_count
//
//  each word is handled in an accept step and a resolve step: the accept edge compares the key in every cell
//  at once, the next edge resolves replace, insert or lookup across the chain
//  and shifts the cells; done is high for one cycle after that.
//  busy is high in the resolve cycle, so no new word is taken until it ends.
//  rst_n clears the entry count and every cell's valid bit; no sweep needed.
//  the receiver cannot stall: the result word counts only while done is high
// ----------------------------------------------------------------------------
module sorted_segment_address_index_top
    import ssai_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic [ADDR_W-1:0]   address,
    input  logic [HANDLE_W-1:0] handle_in,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [ECOUNT_W-1:0] entry_count
);

    state_t  state_reg, state_next;
    logic    mode_reg;
    addr_t   key_reg;
    handle_t op_handle_reg;
    count_t  count_reg, count_next;
    logic    done_reg, done_next;
    status_t status_reg, status_next;
    handle_t handle_out_reg, handle_out_next;

    logic      accept;
    cell_ctl_t ctl;
    addr_t     cmp_key;
    logic      any_eq;
    handle_t   hit_or;
    logic      table_full;

    cell_link_t link [CAPACITY+1];
    logic       eq_vec [CAPACITY];
    handle_t    hit_vec [CAPACITY];

    assign accept     = start && (state_reg == S_IDLE);
    assign cmp_key    = (mode == MODE_LOOKUP) ? (address & ALIGN_MASK) : address;
    assign table_full = (count_reg >= CNT_W'(CAPACITY));

    // chain head: everything left of cell 0 counts as below the key
    assign link[0].key    = '0;
    assign link[0].handle = '0;
    assign link[0].valid  = 1'b0;
    assign link[0].lt     = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            ssai_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .cmp_key    (cmp_key),
                .op_key     (key_reg),
                .op_handle  (op_handle_reg),
                .left       (link[gi]),
                .right      (link[gi+1]),
                .eq         (eq_vec[gi]),
                .hit_handle (hit_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        any_eq = 1'b0;
        hit_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq = any_eq | eq_vec[i];
            hit_or = hit_or | hit_vec[i];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        handle_out_next = '0;
        ctl             = '0;
        ctl.cmp_en      = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (mode_reg == MODE_LOOKUP)
                begin
                    if (any_eq)
                    begin
                        status_next     = ST_HIT;
                        handle_out_next = hit_or;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                else
                begin
                    priority if (key_reg == '0)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else if (any_eq)
                    begin
                        status_next = ST_REPLACED;
                        ctl.replace = 1'b1;
                    end
                    else if (table_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_INSERTED;
                        ctl.insert  = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_out_reg <= handle_out_next;
        if (accept)
        begin
            mode_reg      <= mode;
            key_reg       <= cmp_key;
            op_handle_reg <= handle_in;
        end
    end

    assign busy        = (state_reg == S_RESOLVE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign handle_out  = handle_out_reg;
    assign entry_count = ECOUNT_W'(count_reg);

    // resolve cycle only ever follows an accept
    a_resolve_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> $past(start && !busy))
        else $error("resolve without accept");

    // one result strobe per resolve cycle
    a_done_after_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without resolve");

    // count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // an insert grows the table by one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not bump count");

    // handle is zero unless the result is a hit
    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_HIT)) |-> (handle_out == '0))
        else $error("nonzero handle without hit");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for sorted_segment_address_index_top: a directed table
// of updates and lookups (zero key, unaligned keys, extremes, replace, below
// one segment) followed by random words that fill the table, hit it with
// replaces and lookups, and keep pushing it while full; every result word is
// compared against an in-bench segment table model
// ----------------------------------------------------------------------------
module testbench;
    import ssai_pkg::*;

    localparam int NUM_DIRECTED = 18;
    localparam int NUM_RANDOM   = 1780;
    localparam int IDLE_LIMIT   = 1000;

    typedef struct packed {
        status_t               status;
        handle_t               handle;
        logic [ECOUNT_W-1:0]   count;
    } seg_result_t;

    typedef struct {
        mode_t       m;
        addr_t       a;
        handle_t     h;
        bit          pinned;
        seg_result_t res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                mode = 1'b0;
    logic [ADDR_W-1:0]   address = '0;
    logic [HANDLE_W-1:0] handle_in = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [ECOUNT_W-1:0] entry_count;

    // segment table model
    addr_t   key_tab [CAPACITY];
    handle_t hdl_tab [CAPACITY];
    int      tab_count = 0;

    seg_result_t expected_q [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 1;

    dir_row_t dir_rows [NUM_DIRECTED] = '{
        '{MODE_LOOKUP, 48'h0000_0000_0000, 16'h0000, 1'b1, '{ST_MISS,     16'h0000, 7'd0}},
        '{MODE_UPDATE, 48'h0000_0000_0000, 16'hFFFF, 1'b1, '{ST_IGNORED,  16'h0000, 7'd0}},
        '{MODE_UPDATE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, '{ST_INSERTED, 16'h0000, 7'd1}},
        '{MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 16'h0000, 1'b1, '{ST_MISS,     16'h0000, 7'd1}},
        '{MODE_UPDATE, 48'h0000_0040_0000, 16'h1234, 1'b1, '{ST_INSERTED, 16'h0000, 7'd2}},
        '{MODE_LOOKUP, 48'h0000_007F_FFFF, 16'h0000, 1'b1, '{ST_HIT,      16'h1234, 7'd2}},
        '{MODE_LOOKUP, 48'h0000_003F_FFFF, 16'hFFFF, 1'b1, '{ST_MISS,     16'h0000, 7'd2}},
        '{MODE_UPDATE, 48'h0000_0040_0000, 16'h0000, 1'b1, '{ST_REPLACED, 16'h0000, 7'd2}},
        '{MODE_LOOKUP, 48'h0000_0040_0000, 16'hFFFF, 1'b1, '{ST_HIT,      16'h0000, 7'd2}},
        '{MODE_UPDATE, 48'hFFFF_FFC0_0000, 16'hAAAA, 1'b1, '{ST_INSERTED, 16'h0000, 7'd3}},
        '{MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 16'h5555, 1'b1, '{ST_HIT,      16'hAAAA, 7'd3}},
        '{MODE_UPDATE, 48'h0000_0080_0000, 16'h5555, 1'b0, '{ST_MISS,     16'h0000, 7'd0}},
        '{MODE_UPDATE, 48'h0000_0000_0001, 16'h0001, 1'b0, '{ST_MISS,     16'h0000, 7'd0}},
        '{MODE_LOOKUP, 48'h0000_0080_0001, 16'h0000, 1'b0, '{ST_MISS,     16'h0000, 7'd0}},
        '{MODE_UPDATE, 48'h0000_0000_0001, 16'h8000, 1'b0, '{ST_MISS,     16'h0000, 7'd0}},
        '{MODE_LOOKUP, 48'h0000_0000_0001, 16'h0000, 1'b1, '{ST_MISS,     16'h0000, 7'd5}},
        '{MODE_UPDATE, 48'h8000_0000_0000, 16'h7FFF, 1'b0, '{ST_MISS,     16'h0000, 7'd0}},
        '{MODE_LOOKUP, 48'h8000_003F_FFFF, 16'h0000, 1'b0, '{ST_MISS,     16'h0000, 7'd0}}
    };

    sorted_segment_address_index_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .address     (address),
        .handle_in   (handle_in),
        .done        (done),
        .status      (status),
        .handle_out  (handle_out),
        .entry_count (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic seg_result_t index_apply(input mode_t m, input addr_t a,
                                                input handle_t h);
        seg_result_t r;
        addr_t       key;
        int          pos;
        int          i;
        r.status = ST_MISS;
        r.handle = '0;
        key = (m == MODE_LOOKUP) ? (a & ALIGN_MASK) : a;
        pos = 0;
        while (pos < tab_count && key_tab[pos] < key)
            pos++;
        if (m == MODE_LOOKUP)
        begin
            if (pos < tab_count && key_tab[pos] == key)
            begin
                r.status = ST_HIT;
                r.handle = hdl_tab[pos];
            end
        end
        else if (a == '0)
            r.status = ST_IGNORED;
        else if (pos < tab_count && key_tab[pos] == key)
        begin
            hdl_tab[pos] = h;
            r.status = ST_REPLACED;
        end
        else if (tab_count >= CAPACITY)
            r.status = ST_FULL;
        else
        begin
            for (i = tab_count; i > pos; i--)
            begin
                key_tab[i] = key_tab[i-1];
                hdl_tab[i] = hdl_tab[i-1];
            end
            key_tab[pos] = key;
            hdl_tab[pos] = h;
            tab_count++;
            r.status = ST_INSERTED;
        end
        r.count = ECOUNT_W'(tab_count);
        return r;
    endfunction

    function automatic addr_t rand_addr();
        return addr_t'({$urandom(), $urandom()});
    endfunction

    function automatic addr_t rand_aligned_key();
        addr_t k;
        k = rand_addr() & ALIGN_MASK;
        if (k == '0)
            k[SEGMENT_LOG_SIZE] = 1'b1;
        return k;
    endfunction

    task automatic issue_word(input mode_t m, input addr_t a, input handle_t h,
                              input bit pinned, input seg_result_t pin);
        seg_result_t r;
        int          gap;
        mode      <= m;
        address   <= a;
        handle_in <= h;
        start     <= 1'b1;
        do @(posedge clk); while (busy);
        r = index_apply(m, a, h);
        expected_q.push_back(pinned ? pin : r);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic random_word();
        mode_t   m;
        addr_t   a;
        handle_t h;
        int      sel;
        sel = $urandom_range(0, 99);
        h = handle_t'($urandom());
        if (sel < 30 && tab_count > 0)
        begin
            m = MODE_LOOKUP;
            a = key_tab[$urandom_range(0, tab_count - 1)] | (rand_addr() & ~ALIGN_MASK);
        end
        else if (sel < 45)
        begin
            m = MODE_LOOKUP;
            a = (sel < 33) ? (rand_addr() & ~ALIGN_MASK) : rand_addr();
        end
        else if (sel < 65 && tab_count > 0)
        begin
            m = MODE_UPDATE;
            a = key_tab[$urandom_range(0, tab_count - 1)];
        end
        else if (sel < 93)
        begin
            m = MODE_UPDATE;
            a = rand_aligned_key();
        end
        else if (sel < 97)
        begin
            m = MODE_UPDATE;
            a = rand_addr();
        end
        else
        begin
            m = MODE_UPDATE;
            a = '0;
        end
        issue_word(m, a, h, 1'b0, '0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int k = 0; k < NUM_DIRECTED; k++)
            issue_word(dir_rows[k].m, dir_rows[k].a, dir_rows[k].h,
                       dir_rows[k].pinned, dir_rows[k].res);
        for (int k = 0; k < NUM_RANDOM; k++)
            random_word();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("sorted_segment_address_index_top regression: pass");
        else
            $display("sorted_segment_address_index_top regression: fail");
        $finish;
    end

    // result word check
    always @(posedge clk)
    begin
        seg_result_t exp_word;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d handle=%h count=%0d",
                         $time, status, handle_out, entry_count);
                fail_count++;
            end
            else
            begin
                exp_word = expected_q.pop_front();
                if (status !== exp_word.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_word.status, status);
                    fail_count++;
                end
                if (handle_out !== exp_word.handle)
                begin
                    $display("%0t: handle_out expected %h actual %h",
                             $time, exp_word.handle, handle_out);
                    fail_count++;
                end
                if (entry_count !== exp_word.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp_word.count, entry_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
            $display("sorted_segment_address_index_top regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
